// ----- src/krt_pkg.sv -----
// keyed record table: shared types and constants
// no dependencies; imported by every module of the table
`default_nettype none

package krt_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int PAY_W    = 64;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_LIST   = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_DELETE = 2'd3
	} krt_cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_EMPTY   = 2'd3
	} krt_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_SHIFT
	} krt_state_t;

	typedef struct packed {
		krt_cmd_t                command;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
	} krt_item_t;

	typedef struct packed {
		krt_status_t             status;
		logic signed [KEY_W-1:0] rec_key;
		logic [PAY_W-1:0]        rec_payload;
		logic                    last;
	} krt_result_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
	} krt_rec_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		krt_rec_t         wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} krt_ram_req_t;

endpackage

`default_nettype wire

// ----- src/krt_ram.sv -----
// keyed record table: record memory, one write and one read port
// read data registered; depends on krt_pkg
`default_nettype none

module krt_ram (
	input  wire                   clk,
	input  krt_pkg::krt_ram_req_t req,
	output krt_pkg::krt_rec_t     rdata
);
	import krt_pkg::*;

	krt_rec_t mem [CAPACITY];
	krt_rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- src/krt_ctrl.sv -----
// keyed record table: command sequencer, read pipeline and compaction
// drives krt_ram and produces result beats; depends on krt_pkg
`default_nettype none

module krt_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  krt_pkg::krt_item_t    item,
	output logic                  busy,
	output krt_pkg::krt_ram_req_t req,
	input  krt_pkg::krt_rec_t     rdata,
	output logic                  res_valid,
	output krt_pkg::krt_result_t  res
);
	import krt_pkg::*;

	krt_state_t              state_q, state_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [CNT_W-1:0]        ra_q, ra_d;
	logic                    rd_v_s1, rd_v_d;
	logic [IDX_W-1:0]        rd_a_s1, rd_a_d;
	krt_cmd_t                cmd_q, cmd_d;
	logic signed [KEY_W-1:0] key_q, key_d;
	logic [CNT_W-1:0]        cnt_m1;
	logic                    at_last;
	logic                    key_hit;

	assign cnt_m1  = count_q - CNT_W'(1);
	assign at_last = (rd_a_s1 == cnt_m1[IDX_W-1:0]);
	assign key_hit = (rdata.key == key_q);
	assign busy    = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ra_q    <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ra_q    <= ra_d;
			rd_v_s1 <= rd_v_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_a_s1 <= rd_a_d;
		cmd_q   <= cmd_d;
		key_q   <= key_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ra_d      = ra_q;
		rd_v_d    = 1'b0;
		rd_a_d    = rd_a_s1;
		cmd_d     = cmd_q;
		key_d     = key_q;
		req       = '0;
		res_valid = 1'b0;
		res       = '0;
		unique case (state_q) inside
			S_IDLE: begin
				if (start) begin
					cmd_d = item.command;
					key_d = item.key;
					unique case (item.command) inside
						CMD_APPEND: begin
							res_valid = 1'b1;
							res.last  = 1'b1;
							if (count_q == CNT_W'(CAPACITY)) begin
								res.status = ST_FULL;
							end else begin
								res.status          = ST_OK;
								req.we              = 1'b1;
								req.waddr           = count_q[IDX_W-1:0];
								req.wdata.key       = item.key;
								req.wdata.payload   = item.payload;
								count_d             = count_q + CNT_W'(1);
							end
						end
						CMD_LIST, CMD_SEARCH, CMD_DELETE: begin
							if (count_q == '0) begin
								res_valid  = 1'b1;
								res.last   = 1'b1;
								res.status = (item.command == CMD_LIST) ? ST_EMPTY : ST_MISSING;
							end else begin
								state_d = S_WALK;
								ra_d    = '0;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_WALK, S_SHIFT: begin
				// issue one read per cycle up to the fill count
				if (ra_q < count_q) begin
					req.re    = 1'b1;
					req.raddr = ra_q[IDX_W-1:0];
					ra_d      = ra_q + CNT_W'(1);
					rd_v_d    = 1'b1;
					rd_a_d    = ra_q[IDX_W-1:0];
				end
				if (rd_v_s1) begin
					if (state_q == S_SHIFT) begin
						// move entry down by one to close the gap
						req.we    = 1'b1;
						req.waddr = rd_a_s1 - IDX_W'(1);
						req.wdata = rdata;
						if (at_last) begin
							count_d = cnt_m1;
							state_d = S_IDLE;
							rd_v_d  = 1'b0;
						end
					end else if (cmd_q == CMD_LIST) begin
						res_valid       = 1'b1;
						res.status      = ST_OK;
						res.rec_key     = rdata.key;
						res.rec_payload = rdata.payload;
						res.last        = at_last;
						if (at_last) begin
							state_d = S_IDLE;
							rd_v_d  = 1'b0;
						end
					end else if (key_hit) begin
						res_valid       = 1'b1;
						res.status      = ST_OK;
						res.rec_key     = rdata.key;
						res.rec_payload = rdata.payload;
						res.last        = 1'b1;
						if (cmd_q == CMD_SEARCH) begin
							state_d = S_IDLE;
							rd_v_d  = 1'b0;
						end else if (at_last) begin
							count_d = cnt_m1;
							state_d = S_IDLE;
							rd_v_d  = 1'b0;
						end else begin
							state_d = S_SHIFT;
						end
					end else if (at_last) begin
						res_valid  = 1'b1;
						res.status = ST_MISSING;
						res.last   = 1'b1;
						state_d    = S_IDLE;
						rd_v_d     = 1'b0;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/keyed_record_table_core.sv -----
// keyed record table: top level with result register and checks
// depends on krt_pkg, krt_ram, krt_ctrl
`default_nettype none

// Table of up to 64 records (signed 32-bit key, 64-bit payload) kept in
// insertion order in one memory with a registered read. A command is taken
// when start is high and busy is low; every result beat shows on result for
// exactly one cycle with strobe high, in the cycle after the controller
// forms it (a record beat passes the memory read register and then the
// result register), and must be taken then. Append, and any command on an
// empty table, gives its beat in the cycle after start and leaves busy low,
// so the next command may follow at once. List, search and delete walk the
// table through the single read port one entry per cycle: list sends count
// beats on consecutive cycles; search stops at the first hit or walks every
// entry for a miss; delete reads and writes back each later entry once.
// There is no clearing pass after reset.
module keyed_record_table_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  krt_pkg::krt_item_t   item,
	output logic                 busy,
	output logic                 strobe,
	output krt_pkg::krt_result_t result
);
	import krt_pkg::*;

	krt_ram_req_t req;
	krt_rec_t     rdata;
	logic         res_valid;
	krt_result_t  res;
	logic         strobe_q;
	krt_result_t  result_q;

	krt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.busy      (busy),
		.req       (req),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res       (res)
	);

	krt_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			result_q <= res;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// an accepted command either answers at once or starts a walk
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe || busy)
		else $error("accepted command neither answered nor started a walk");

	// every status other than ok ends its command
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status != ST_OK |-> result.last)
		else $error("error status without last");

	// list beats come back to back until the last one
	a_list_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("gap in list beats");

endmodule

`default_nettype wire

// ----- dv/keyed_record_table_core_tb.sv -----
// testbench for keyed_record_table_core: directed and random command streams
// checks every result beat against an in-bench table of records
// depends on krt_pkg and the keyed_record_table_core rtl
module keyed_record_table_core_tb;
	import krt_pkg::*;

	localparam int LIMIT = 300000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	krt_item_t   item = '0;
	logic        busy;
	logic        strobe;
	krt_result_t result;

	keyed_record_table_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	always #5 clk = ~clk;

	krt_item_t               command_backlog[$];
	krt_result_t             reply_beats[$];
	logic signed [KEY_W-1:0] rec_keys[CAPACITY];
	logic [PAY_W-1:0]        rec_pays[CAPACITY];
	int                      rec_count = 0;
	logic signed [KEY_W-1:0] key_pool[8];
	int                      total_cmds = 0;
	int                      taken_cmds = 0;
	int                      mismatches = 0;
	int                      cycle_count = 0;

	function automatic void run_table_command(krt_item_t it);
		krt_result_t r;
		int          hit;
		r = '0;
		r.last = 1'b1;
		hit = -1;
		case (it.command)
			CMD_APPEND: begin
				if (rec_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					rec_keys[rec_count] = it.key;
					rec_pays[rec_count] = it.payload;
					rec_count++;
					r.status = ST_OK;
				end
				reply_beats.push_back(r);
			end
			CMD_LIST: begin
				if (rec_count == 0) begin
					r.status = ST_EMPTY;
					reply_beats.push_back(r);
				end else begin
					for (int i = 0; i < rec_count; i++) begin
						r.status = ST_OK;
						r.rec_key = rec_keys[i];
						r.rec_payload = rec_pays[i];
						r.last = (i == rec_count - 1);
						reply_beats.push_back(r);
					end
				end
			end
			default: begin
				for (int i = 0; i < rec_count; i++) begin
					if (hit < 0 && rec_keys[i] == it.key)
						hit = i;
				end
				if (hit < 0) begin
					r.status = ST_MISSING;
				end else begin
					r.status = ST_OK;
					r.rec_key = rec_keys[hit];
					r.rec_payload = rec_pays[hit];
					if (it.command == CMD_DELETE) begin
						for (int j = hit; j + 1 < rec_count; j++) begin
							rec_keys[j] = rec_keys[j + 1];
							rec_pays[j] = rec_pays[j + 1];
						end
						rec_count--;
					end
				end
				reply_beats.push_back(r);
			end
		endcase
	endfunction

	function automatic void queue_cmd(krt_cmd_t c, logic signed [KEY_W-1:0] k,
			logic [PAY_W-1:0] p);
		krt_item_t it;
		it.command = c;
		it.key = k;
		it.payload = p;
		command_backlog.push_back(it);
	endfunction

	function automatic logic [PAY_W-1:0] any_payload();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key(int pool_pct);
		if ($urandom_range(0, 99) < pool_pct)
			return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic int gap_pct();
		case (taken_cmds * 3 / total_cmds)
			0: return 20;
			1: return 47;
			default: return 0;
		endcase
	endfunction

	task automatic check_field(string name, logic [PAY_W-1:0] want,
			logic [PAY_W-1:0] got);
		if (got !== want) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// driver: start held until the command is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				run_table_command(item);
				taken_cmds++;
			end
			if (!start || !busy) begin
				if (command_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct()) begin
					start <= 1'b1;
					item <= command_backlog.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		krt_result_t want;
		if (arst_n && strobe !== 1'b0) begin
			if (strobe !== 1'b1 || reply_beats.size() == 0) begin
				$display("%0t unexpected beat: expected none actual %0h", $time, result);
				mismatches++;
			end else begin
				want = reply_beats.pop_front();
				check_field("status", PAY_W'(want.status), PAY_W'(result.status));
				check_field("rec_key", PAY_W'(want.rec_key), PAY_W'(result.rec_key));
				check_field("rec_payload", want.rec_payload, result.rec_payload);
				check_field("last", PAY_W'(want.last), PAY_W'(result.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		localparam logic signed [KEY_W-1:0] KMIN = 32'sh8000_0000;
		localparam logic signed [KEY_W-1:0] KMAX = 32'sh7fff_ffff;
		bit first_fill;
		first_fill = 1'b1;
		key_pool[0] = KMIN;
		key_pool[1] = KMAX;
		key_pool[2] = 0;
		key_pool[3] = -1;
		for (int i = 4; i < 8; i++)
			key_pool[i] = $urandom;

		// directed
		queue_cmd(CMD_LIST, 0, '0);
		queue_cmd(CMD_SEARCH, 0, '0);
		queue_cmd(CMD_DELETE, 0, '0);
		queue_cmd(CMD_APPEND, KMIN, '0);
		queue_cmd(CMD_APPEND, KMAX, '1);
		queue_cmd(CMD_APPEND, KMIN, 64'h0123_4567_89ab_cdef);
		queue_cmd(CMD_APPEND, -1, {$urandom, $urandom});
		queue_cmd(CMD_SEARCH, KMIN, '0);
		queue_cmd(CMD_LIST, 0, '0);
		queue_cmd(CMD_DELETE, KMAX, '0);
		queue_cmd(CMD_DELETE, KMIN, '0);
		queue_cmd(CMD_SEARCH, KMIN, '0);
		queue_cmd(CMD_SEARCH, 5, '0);
		queue_cmd(CMD_DELETE, 12345, '0);
		queue_cmd(CMD_DELETE, -1, '0);
		queue_cmd(CMD_DELETE, KMIN, '0);
		queue_cmd(CMD_LIST, 0, '0);

		// random bursts, some filling the table past capacity
		while (command_backlog.size() < 480) begin
			if (first_fill || $urandom_range(0, 9) == 0) begin
				first_fill = 1'b0;
				for (int i = 4; i < 8; i++)
					key_pool[i] = $urandom;
				for (int i = 0; i < CAPACITY + 4; i++)
					queue_cmd(CMD_APPEND, pick_key(80), any_payload());
				queue_cmd(CMD_LIST, $urandom, any_payload());
				queue_cmd(CMD_SEARCH, pick_key(85), any_payload());
			end else begin
				for (int i = 0; i < 10; i++) begin
					case ($urandom_range(0, 99)) inside
						[0:34]:  queue_cmd(CMD_APPEND, pick_key(80), any_payload());
						[35:44]: queue_cmd(CMD_LIST, $urandom, any_payload());
						[45:69]: queue_cmd(CMD_SEARCH, pick_key(85), any_payload());
						default: queue_cmd(CMD_DELETE, pick_key(85), any_payload());
					endcase
				end
			end
		end
		total_cmds = command_backlog.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (command_backlog.size() != 0 || start) @(posedge clk);
		while (reply_beats.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/krt_pkg.sv
src/krt_ram.sv
src/krt_ctrl.sv
src/keyed_record_table_core.sv
dv/keyed_record_table_core_tb.sv
